// File: sv/prr_pkg.sv
// Package for the phasor reference rotator: shared constants, types, CORDIC table.
// No dependencies; used by every module of the block except prr_ram.
package prr_pkg;
  localparam int Channels = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int CordicSteps = 24;
  localparam int StepW = 5;

  localparam logic [1:0] REG_DC_MODE = 2'd0;
  localparam logic [1:0] REG_REF_ON = 2'd1;
  localparam logic [1:0] REG_REF_INDEX = 2'd2;

  typedef struct packed {
    logic [31:0] chan_re;
    logic [31:0] chan_im;
    logic        last_channel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_re;
    logic [31:0] out_im;
    logic [31:0] magnitude;
    logic [15:0] angle_turns;
    logic        last_result;
  } out_item_t;

  // Datapath operations, one-hot, issued by the controller.
  typedef enum logic [7:0] {
    OP_NONE   = 8'b0000_0001,
    OP_LOAD   = 8'b0000_0010,
    OP_TINIT  = 8'b0000_0100,
    OP_TDIV   = 8'b0000_1000,
    OP_ROT    = 8'b0001_0000,
    OP_MUL    = 8'b0010_0000,
    OP_SQRT   = 8'b0100_0000,
    OP_CORDIC = 8'b1000_0000
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        first;   // first cycle of an iterative operation
    logic        ref_sel; // loaded vector is the reference channel
  } dp_cmd_t;

  typedef struct packed {
    logic busy;           // iterative operation still running
  } dp_sts_t;

  function automatic logic [31:0] atan_turns(input logic [StepW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage

// File: sv/prr_if.sv
// Valid/ready channel interfaces for the phasor reference rotator.
// Depends on prr_pkg for the payload types.
interface prr_in_if;
  logic valid;
  logic ready;
  prr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prr_out_if;
  logic valid;
  logic ready;
  prr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/prr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module prr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/prr_datapath.sv
// Datapath: correction, turn-vector build (sqrt and division), rotation,
// magnitude and CORDIC angle. Depends on prr_pkg.
module prr_datapath (
  input  logic                clk,
  input  logic                dc_mode,
  input  logic [63:0]         rd_data,
  input  prr_pkg::dp_cmd_t    cmd,
  output prr_pkg::dp_sts_t    sts,
  output logic [31:0]         res_re,
  output logic [31:0]         res_im,
  output logic [31:0]         res_mag,
  output logic [15:0]         res_ang
);
  // Corrected vector of the loaded entry.
  logic signed [31:0] a_r, b_r;
  logic signed [31:0] turn_re_r, turn_im_r;
  // Turn build: |a|, |b| scaled, sqrt, two divisions.
  logic [63:0]  s_r;
  logic [6:0]   k_r;
  logic [31:0]  m_r;
  logic [64:0]  sq_rem_r;
  logic [31:0]  sq_root_r;
  logic [5:0]   cnt_r;
  logic [95:0]  num_re_r, num_im_r;
  logic [95:0]  q_re_r, q_im_r;
  logic [32:0]  rm_re_r, rm_im_r;
  logic         neg_a_r, neg_b_r;
  logic [1:0]   phase_r;
  // Rotation products and outputs.
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] or_r, oi_r;
  logic [63:0]  msq_r;
  logic [31:0]  mag_r;
  logic signed [33:0] cx_r, cy_r;
  logic [31:0]  acc_r;
  logic [15:0]  ang_r;

  logic signed [31:0] ld_re, ld_im, cor_re, cor_im;
  logic [31:0] ua, ub;
  logic busy_nxt;

  assign ld_re = rd_data[31:0];
  assign ld_im = rd_data[63:32];
  always_comb begin
    if (dc_mode) begin
      cor_re = ld_re >>> 1;
      cor_im = ld_im;
    end else begin
      cor_re = ld_re;
      cor_im = (ld_im == 32'sh8000_0000) ? 32'sh7fff_ffff : -ld_im;
    end
  end
  assign ua = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign ub = b_r[31] ? (~b_r + 32'd1) : b_r;

  function automatic logic signed [31:0] rnd_sat(input logic signed [64:0] x);
    logic [64:0] mg;
    logic [65:0] q;
    begin
      mg = x[64] ? (~x + 65'd1) : x;
      q = ({1'b0, mg} + 66'd536870912) >> 30;
      if (!x[64] && q > 66'd2147483647) return 32'sh7fff_ffff;
      if (x[64] && q > 66'd2147483648) return 32'sh8000_0000;
      return x[64] ? -q[31:0] : q[31:0];
    end
  endfunction

  // Registered datapath operations; the restoring division keeps the numerator in the upper 64 bits, one bit a cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      prr_pkg::OP_LOAD: begin
        a_r <= cor_re;
        b_r <= cor_im;
      end
      prr_pkg::OP_TINIT: begin
        if (cmd.first) begin
          turn_re_r <= 32'sh4000_0000;
          turn_im_r <= '0;
          phase_r <= 2'd0;
          neg_a_r <= a_r[31];
          neg_b_r <= b_r[31];
          s_r <= 64'(ua) * 64'(ua);
          k_r <= '0;
        end else if (phase_r == 2'd0) begin
          s_r <= s_r + 64'(ub) * 64'(ub);
          phase_r <= 2'd1;
        end else if (s_r != 64'd0 && s_r < 64'h1000_0000_0000_0000) begin
          s_r <= s_r << 2;
          k_r <= k_r + 7'd1;
        end
      end
      prr_pkg::OP_SQRT: begin
        // Digit-by-digit square root of s_r, two bits per cycle.
        if (cmd.first) begin
          sq_rem_r <= '0;
          sq_root_r <= '0;
          cnt_r <= 6'd31;
          msq_r <= s_r;
        end else begin
          logic [64:0] rem2;
          logic [64:0] trial;
          rem2 = {sq_rem_r[62:0], msq_r[63:62]};
          trial = {31'd0, sq_root_r, 2'b01};
          msq_r <= msq_r << 2;
          if (rem2 >= trial) begin
            sq_rem_r <= rem2 - trial;
            sq_root_r <= {sq_root_r[30:0], 1'b1};
          end else begin
            sq_rem_r <= rem2;
            sq_root_r <= {sq_root_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          m_r <= {sq_root_r[30:0], (rem2 >= trial)};
        end
      end
      prr_pkg::OP_TDIV: begin
        if (cmd.first) begin
          num_re_r <= (((96'(ua) << k_r) << 30) + 96'(m_r >> 1)) << 32;
          num_im_r <= (((96'(ub) << k_r) << 30) + 96'(m_r >> 1)) << 32;
          rm_re_r <= '0;
          rm_im_r <= '0;
          cnt_r <= 6'd0;
        end else begin
          logic [32:0] t_re, t_im;
          t_re = {rm_re_r[31:0], num_re_r[95]};
          t_im = {rm_im_r[31:0], num_im_r[95]};
          num_re_r <= num_re_r << 1;
          num_im_r <= num_im_r << 1;
          if (t_re >= {1'b0, m_r}) begin
            rm_re_r <= t_re - {1'b0, m_r};
            q_re_r <= {q_re_r[94:0], 1'b1};
          end else begin
            rm_re_r <= t_re;
            q_re_r <= {q_re_r[94:0], 1'b0};
          end
          if (t_im >= {1'b0, m_r}) begin
            rm_im_r <= t_im - {1'b0, m_r};
            q_im_r <= {q_im_r[94:0], 1'b1};
          end else begin
            rm_im_r <= t_im;
            q_im_r <= {q_im_r[94:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            // Last quotient bits land in this cycle; write signed turn next op.
          end
        end
      end
      prr_pkg::OP_ROT: begin
        if (cmd.first) begin
          if (s_r != 64'd0) begin
            turn_re_r <= neg_a_r ? -q_re_r[31:0] : q_re_r[31:0];
            turn_im_r <= neg_b_r ? q_im_r[31:0] : -q_im_r[31:0];
          end
        end else begin
          p0_r <= 64'(a_r) * 64'(turn_re_r);
          p1_r <= 64'(b_r) * 64'(turn_im_r);
          p2_r <= 64'(a_r) * 64'(turn_im_r);
          p3_r <= 64'(b_r) * 64'(turn_re_r);
        end
      end
      prr_pkg::OP_MUL: begin
        if (cmd.first) begin
          or_r <= rnd_sat(65'(p0_r) - 65'(p1_r));
          oi_r <= rnd_sat(65'(p2_r) + 65'(p3_r));
        end else begin
          // The second square is added by the next non-first OP_TINIT, through b_r.
          logic [31:0] mr;
          mr = or_r[31] ? (~or_r + 32'd1) : or_r;
          s_r <= 64'(mr) * 64'(mr);
          b_r <= oi_r;
          phase_r <= 2'd0;
        end
      end
      prr_pkg::OP_CORDIC: begin
        if (cmd.first) begin
          // Magnitude square root result is in sq_root_r.
          mag_r <= sq_root_r;
          cnt_r <= '0;
          if (or_r[31]) begin
            cx_r <= -34'(or_r);
            cy_r <= -34'(oi_r);
            acc_r <= 32'h8000_0000;
          end else begin
            cx_r <= 34'(or_r);
            cy_r <= 34'(oi_r);
            acc_r <= '0;
          end
        end else begin
          if (cy_r > 0) begin
            cx_r <= cx_r + (cy_r >>> cnt_r);
            cy_r <= cy_r - (cx_r >>> cnt_r);
            acc_r <= acc_r + prr_pkg::atan_turns(cnt_r[4:0]);
          end else begin
            cx_r <= cx_r - (cy_r >>> cnt_r);
            cy_r <= cy_r + (cx_r >>> cnt_r);
            acc_r <= acc_r - prr_pkg::atan_turns(cnt_r[4:0]);
          end
          cnt_r <= cnt_r + 6'd1;
        end
      end
      default: begin
      end
    endcase
    if (cmd.op == prr_pkg::OP_CORDIC && !cmd.first && cnt_r == 6'(prr_pkg::CordicSteps - 1))
    begin
      ang_r <= (or_r == 0 && oi_r == 0) ? 16'd0
             : 16'((acc_r + ((cy_r > 0) ? prr_pkg::atan_turns(cnt_r[4:0])
                                      : -prr_pkg::atan_turns(cnt_r[4:0]))
                    + 32'h8000) >> 16);
    end
  end

  // The magnitude square root reuses the sqrt stepper: sum squares first.
  always_comb begin
    busy_nxt = 1'b0;
    case (cmd.op)
      prr_pkg::OP_TINIT: busy_nxt = cmd.first || phase_r == 2'd0 ||
                                    (s_r != 64'd0 && s_r < 64'h1000_0000_0000_0000);
      prr_pkg::OP_SQRT:  busy_nxt = cmd.first || cnt_r != 6'd0;
      prr_pkg::OP_TDIV:  busy_nxt = cmd.first || cnt_r != 6'd63;
      prr_pkg::OP_CORDIC: busy_nxt = cmd.first || cnt_r != 6'(prr_pkg::CordicSteps - 1);
      default: busy_nxt = 1'b0;
    endcase
  end
  assign sts.busy = busy_nxt;

  assign res_re = or_r;
  assign res_im = oi_r;
  assign res_mag = mag_r;
  assign res_ang = ang_r;
endmodule

// File: sv/prr_ctrl.sv
// Controller: fills the store, then for the set builds the turn vector (when a turn applies) and
// walks every entry through rotation, magnitude and angle. Depends on prr_pkg.
module prr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      dc_mode,
  input  logic                      ref_on,
  input  logic [prr_pkg::IdxW-1:0]  ref_index,
  input  logic                      in_fire,
  input  logic                      in_last,
  output logic                      in_rdy,
  output logic                      wr_en,
  output logic [prr_pkg::IdxW-1:0]  wr_addr,
  output logic [prr_pkg::IdxW-1:0]  rd_addr,
  output prr_pkg::dp_cmd_t          cmd,
  input  prr_pkg::dp_sts_t          sts,
  output logic                      res_valid,
  output logic                      res_last,
  input  logic                      res_ready
);
  typedef enum logic [10:0] {
    S_FILL   = 11'b000_0000_0001,
    S_RLOAD  = 11'b000_0000_0010,
    S_RWAIT  = 11'b000_0000_0100,
    S_TINIT  = 11'b000_0000_1000,
    S_TSQRT  = 11'b000_0001_0000,
    S_TDIV   = 11'b000_0010_0000,
    S_LOAD   = 11'b000_0100_0000,
    S_ROT    = 11'b000_1000_0000,
    S_MUL    = 11'b001_0000_0000,
    S_MSQ    = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [prr_pkg::CntW-1:0] fill_r, fill_nxt;
  logic [prr_pkg::CntW-1:0] k_r, k_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic first_r, first_nxt;
  logic do_turn;

  assign do_turn = !dc_mode && ref_on && ({1'b0, ref_index} < fill_r);
  assign in_rdy = (state_r == S_FILL);
  assign wr_en = in_fire && fill_r < prr_pkg::CntW'(prr_pkg::Channels);
  assign wr_addr = fill_r[prr_pkg::IdxW-1:0];
  assign rd_addr = (state_r == S_RLOAD) ? ref_index : k_r[prr_pkg::IdxW-1:0];
  assign res_valid = (state_r == S_EMIT);
  assign res_last = (k_r + 1'b1 == fill_r);

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    k_nxt = k_r;
    sub_nxt = sub_r;
    first_nxt = 1'b0;
    cmd.op = prr_pkg::OP_NONE;
    cmd.first = first_r;
    cmd.ref_sel = 1'b0;
    case (state_r)
      S_FILL: begin
        if (in_fire) begin
          fill_nxt = fill_r + (wr_en ? 1'b1 : 1'b0);
          if (in_last || fill_nxt == prr_pkg::CntW'(prr_pkg::Channels)) begin
            state_nxt = S_RLOAD;
            k_nxt = '0;
          end
        end
      end
      S_RLOAD: state_nxt = S_RWAIT;
      S_RWAIT: begin
        cmd.op = prr_pkg::OP_LOAD;
        cmd.ref_sel = 1'b1;
        state_nxt = S_TINIT;
        first_nxt = 1'b1;
      end
      S_TINIT: begin
        // Without a turn the state moves on as soon as the first step has set the unity turn.
        cmd.op = prr_pkg::OP_TINIT;
        if (!do_turn || !sts.busy) begin
          state_nxt = do_turn ? S_TSQRT : S_LOAD;
          first_nxt = do_turn;
        end
      end
      S_TSQRT: begin
        cmd.op = prr_pkg::OP_SQRT;
        if (!sts.busy) begin
          state_nxt = S_TDIV;
          first_nxt = 1'b1;
        end
      end
      S_TDIV: begin
        cmd.op = prr_pkg::OP_TDIV;
        if (!sts.busy) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // sub 0: address settles, sub 1: data registered and loaded.
        sub_nxt = sub_r + 3'd1;
        if (sub_r == 3'd1) begin
          cmd.op = prr_pkg::OP_LOAD;
          sub_nxt = '0;
          state_nxt = S_ROT;
          first_nxt = 1'b1;
        end
      end
      S_ROT: begin
        // first cycle latches the turn vector only once per set (k zero), and only when a turn applies.
        cmd.op = prr_pkg::OP_ROT;
        cmd.first = first_r && (k_r == '0) && do_turn;
        if (!first_r) begin
          state_nxt = S_MUL;
          first_nxt = 1'b1;
        end
      end
      S_MUL: begin
        cmd.op = prr_pkg::OP_MUL;
        if (!first_r) begin
          state_nxt = S_MSQ;
          sub_nxt = '0;
        end
      end
      S_MSQ: begin
        // sub 0: add the second square into s_r, then sqrt, then CORDIC.
        case (sub_r)
          3'd0: begin
            cmd.op = prr_pkg::OP_TINIT;
            cmd.first = 1'b0;
            sub_nxt = 3'd1;
          end
          3'd1: begin
            cmd.op = prr_pkg::OP_SQRT;
            cmd.first = 1'b1;
            sub_nxt = 3'd2;
          end
          3'd2: begin
            cmd.op = prr_pkg::OP_SQRT;
            cmd.first = 1'b0;
            if (!sts.busy) begin
              sub_nxt = 3'd3;
            end
          end
          3'd3: begin
            cmd.op = prr_pkg::OP_CORDIC;
            cmd.first = 1'b1;
            sub_nxt = 3'd4;
          end
          default: begin
            cmd.op = prr_pkg::OP_CORDIC;
            cmd.first = 1'b0;
            if (!sts.busy) begin
              state_nxt = S_EMIT;
              sub_nxt = '0;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (res_ready) begin
          if (res_last) begin
            state_nxt = S_FILL;
            fill_nxt = '0;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r <= '0;
      k_r <= '0;
      sub_r <= '0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      k_r <= k_nxt;
      sub_r <= sub_nxt;
      first_r <= first_nxt;
    end
  end
endmodule

// File: sv/phasor_reference_rotator_top.sv
// Phasor reference rotator: collects up to 16 channel vectors, then emits them
// corrected and turned to the reference angle. Items are taken one per cycle
// while filling; after the closing item the set-up loads the reference and, with a
// turn, builds it (normalization, 32-step square root, both 64-step divisions
// side by side), then each result passes through load, rotate, round, 32-step square
// root, 24-step CORDIC and emit, held while the output stalls. Synchronous active-low reset
// clears the controller and configuration; the vector store is not cleared.
module phasor_reference_rotator_top (
  input  logic        clk,
  input  logic        rst_n,
  prr_in_if.sink      in_ch,
  prr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  logic dc_mode_r, ref_on_r;
  logic [prr_pkg::IdxW-1:0] ref_index_r;
  logic wr_en, in_fire;
  logic [prr_pkg::IdxW-1:0] wr_addr, rd_addr;
  logic [63:0] rd_data;
  prr_pkg::dp_cmd_t cmd;
  prr_pkg::dp_sts_t sts;
  logic res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_mode_r <= 1'b0;
      ref_on_r <= 1'b0;
      ref_index_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        prr_pkg::REG_DC_MODE: dc_mode_r <= cfg_data[0];
        prr_pkg::REG_REF_ON: ref_on_r <= cfg_data[0];
        prr_pkg::REG_REF_INDEX: ref_index_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  prr_ram #(.WIDTH(64), .DEPTH(prr_pkg::Channels)) u_store (
    .clk(clk), .we(wr_en), .waddr(wr_addr),
    .wdata({in_ch.data.chan_im, in_ch.data.chan_re}),
    .raddr(rd_addr), .rdata(rd_data)
  );

  prr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .dc_mode(dc_mode_r), .ref_on(ref_on_r),
    .ref_index(ref_index_r), .in_fire(in_fire), .in_last(in_ch.data.last_channel),
    .in_rdy(in_ch.ready), .wr_en(wr_en), .wr_addr(wr_addr), .rd_addr(rd_addr),
    .cmd(cmd), .sts(sts), .res_valid(out_ch.valid), .res_last(res_last),
    .res_ready(out_ch.ready)
  );

  prr_datapath u_dp (
    .clk(clk), .dc_mode(dc_mode_r), .rd_data(rd_data), .cmd(cmd), .sts(sts),
    .res_re(out_ch.data.out_re), .res_im(out_ch.data.out_im),
    .res_mag(out_ch.data.magnitude), .res_ang(out_ch.data.angle_turns)
  );
  assign out_ch.data.last_result = res_last;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while emitting");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_write_only_fill: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> in_ch.ready) else $error("store written outside fill");
`endif
endmodule
